### rtl/dqd_pkg.sv
// shared types and codes for the deque with delete by value
package dqd_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_TAKE_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_PUT_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_t;

endpackage

### rtl/deque_with_delete_by_value.sv
// deque with delete by value: one request channel, one response channel.
// each req transaction carries an operation (push back, pop back, take front,
// put front, delete first match) and a value; each yields exactly one rsp
// transaction with the removed value, a status and the entry count after it.
// requests are taken one at a time: req_stall stays high from acceptance
// until the result has moved into the output register.
// push back, put front and unused codes go straight to the done state;
// pop back and take front pass read and load (one registered store read).
// delete walks the ring one entry per store access: a compare pass and then
// a read/write pair per entry moved.
// the output register lets the next request be accepted while a result waits
// under rsp_stall; a held result keeps its payload until taken.
// reset empties the queue (front and count cleared) and drops any pending
// result; the store contents are not cleared.
module deque_with_delete_by_value
    import dqd_pkg::*;
#(
    parameter int CAPACITY = 16
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      res_valid;
    logic                      res_stall;
    rsp_t                      res;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;
    logic signed [VALUE_W-1:0] mem_rdata;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;
    logic load;

    dqd_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    dqd_ram #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register frees when empty or taken this cycle
    assign res_stall = rsp_valid_reg && rsp_stall;
    assign load      = res_valid && !res_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/dqd_ram.sv
// entry store: one write port, one registered read port
module dqd_ram
    import dqd_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)(
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic signed [VALUE_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic signed [VALUE_W-1:0] rdata
);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/dqd_ctrl.sv
// sequencer for all operations: ring pointers, slot adder and match compare for delete
module dqd_ctrl
    import dqd_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  req_t                      req,
    output logic                      res_valid,
    input  logic                      res_stall,
    output rsp_t                      res,
    output logic                      mem_we,
    output logic [IDX_W-1:0]          mem_waddr,
    output logic signed [VALUE_W-1:0] mem_wdata,
    output logic [IDX_W-1:0]          mem_raddr,
    input  logic signed [VALUE_W-1:0] mem_rdata
);

    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_LOAD = 6'b000100,
        S_CMP  = 6'b001000,
        S_MOVE = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [OP_W-1:0]           op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]          front_reg, front_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      shift_reg, shift_next;
    logic signed [VALUE_W-1:0] rval_reg, rval_next;
    logic [STAT_W-1:0]         rstat_reg, rstat_next;

    logic [SUM_W-1:0] idx_p1, idx_p2, cnt_s;
    logic [IDX_W-1:0] front_dec;

    // ring slot of the entry at offset off from base
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [SUM_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + off;
        if (s >= CAP_S)
        begin
            s = s - CAP_S;
        end
        return s[IDX_W-1:0];
    endfunction

    assign idx_p1    = SUM_W'(idx_reg) + SUM_W'(1);
    assign idx_p2    = SUM_W'(idx_reg) + SUM_W'(2);
    assign cnt_s     = SUM_W'(count_reg);
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - IDX_W'(1);

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.value_out   = rval_reg;
    assign res.status      = rstat_reg;
    assign res.entry_count = COUNT_W'(count_reg);

    // read address for the pending removal or scan step
    always_comb
    begin
        priority if (op_reg == OP_POP_BACK)
        begin
            mem_raddr = slot(front_reg, cnt_s - SUM_W'(1));
        end
        else if (op_reg == OP_TAKE_FRONT)
        begin
            mem_raddr = front_reg;
        end
        else if (shift_reg)
        begin
            mem_raddr = slot(front_reg, idx_p1);
        end
        else
        begin
            mem_raddr = slot(front_reg, SUM_W'(idx_reg));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        rval_next  = rval_reg;
        rstat_next = rstat_reg;
        mem_we     = 1'b0;
        mem_waddr  = slot(front_reg, cnt_s);
        mem_wdata  = req.value_in;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    val_next   = req.value_in;
                    rval_next  = '0;
                    rstat_next = ST_OK;
                    idx_next   = '0;
                    shift_next = 1'b0;
                    state_next = S_DONE;
                    unique case (req.operation)
                        OP_PUSH_BACK:
                        begin
                            if (cnt_s >= CAP_S)
                            begin
                                rstat_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PUT_FRONT:
                        begin
                            if (cnt_s >= CAP_S)
                            begin
                                rstat_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_BACK, OP_TAKE_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = ST_NOMATCH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                priority if (op_reg != OP_DELETE)
                begin
                    state_next = S_LOAD;
                end
                else if (shift_reg)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_LOAD:
            begin
                rval_next  = mem_rdata;
                count_next = count_reg - CNT_W'(1);
                if (op_reg == OP_TAKE_FRONT)
                begin
                    front_next = slot(front_reg, SUM_W'(1));
                end
                state_next = S_DONE;
            end
            S_CMP:
            begin
                if (mem_rdata == val_reg)
                begin
                    if (idx_p1 < cnt_s)
                    begin
                        // close the gap from here on
                        shift_next = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
                else if (idx_p1 < cnt_s)
                begin
                    idx_next   = idx_p1[CNT_W-1:0];
                    state_next = S_READ;
                end
                else
                begin
                    rstat_next = ST_NOMATCH;
                    state_next = S_DONE;
                end
            end
            S_MOVE:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot(front_reg, SUM_W'(idx_reg));
                mem_wdata = mem_rdata;
                if (idx_p2 < cnt_s)
                begin
                    idx_next   = idx_p1[CNT_W-1:0];
                    state_next = S_READ;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            shift_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        rval_reg  <= rval_next;
        rstat_reg <= rstat_next;
    end

endmodule
